### design/thcs_pkg.sv
// Shared types and constants for the tournament Hamiltonian cycle search core.
// Used by thcs_follow_unit and tournament_hamiltonian_cycle_search_core.
`default_nettype none

package thcs_pkg;

  localparam int MAX_NODES_DEFAULT = 16;
  localparam int NODE_CAP          = 16;
  localparam int NODE_W            = 4;
  localparam int OUTCOME_W         = 2;
  localparam int COUNT_W           = 5;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 5'd16;

  localparam logic [OUTCOME_W-1:0] OUT_WIN  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_LOSS = 2'd2;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic                 en;
    logic [NODE_W-1:0]    row;
    logic [NODE_W-1:0]    col;
    logic [OUTCOME_W-1:0] outcome;
  } table_write_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_TRY,
    S_TRY_EV,
    S_CLOSE,
    S_CLOSE_EV,
    S_REACH,
    S_REACH_EV,
    S_RET,
    S_EMIT,
    S_EMIT_NF
  } search_state_t;

endpackage

`default_nettype wire

### design/thcs_follow_unit.sv
// Match table memory and the shared "may b follow a" evaluator.
// Depends on thcs_pkg; the read data is registered, so a query is answered in the cycle after it is made.
`default_nettype none

module thcs_follow_unit #(
  parameter int MAX_NODES = thcs_pkg::MAX_NODES_DEFAULT,
  parameter int IW        = 4
) (
  input  wire                 clk,
  input  wire thcs_pkg::table_write_t wr,
  input  wire [IW-1:0]        qa,
  input  wire [IW-1:0]        qb,
  output logic                follow
);
  import thcs_pkg::*;

  localparam int LIM       = (MAX_NODES < NODE_CAP) ? MAX_NODES : NODE_CAP;
  localparam int TBL_DEPTH = 1 << (2 * IW);

  logic [OUTCOME_W-1:0] tbl [TBL_DEPTH];
  logic [OUTCOME_W-1:0] rd_fwd;
  logic [OUTCOME_W-1:0] rd_rev;
  logic                 wr_ok;

  assign wr_ok = wr.en && (32'(wr.row) < LIM) && (32'(wr.col) < LIM);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      tbl[{wr.row[IW-1:0], wr.col[IW-1:0]}] <= wr.outcome;
    end
  end

  always_ff @(posedge clk) begin
    rd_fwd <= tbl[{qa, qb}];
    rd_rev <= tbl[{qb, qa}];
  end

  assign follow = (rd_fwd == OUT_WIN) || (rd_rev == OUT_LOSS);

endmodule

`default_nettype wire

### design/tournament_hamiltonian_cycle_search_core.sv
// Top level of the tournament Hamiltonian cycle search: sequencer, path stack and output register.
// Depends on thcs_pkg and thcs_follow_unit.
//
// Channel   Dir  Handshake            Contents
// s_*       in   s_tvalid/s_tready    tuser = mode; tdata = row_node, col_node, outcome
// m_*       out  m_tvalid/m_tready    tdata = node_index, found; tlast = last
// cfg_*     in   cfg_wen              cfg_wdata = node_count
//
// Load requests stream back to back. A search tries each start node in turn and grows a path
// depth first: it scans the candidate successors, checks whether the path closes back to the
// start once it holds every node, scans for an unvisited node that can still reach the start,
// and backtracks when no candidate remains or no such node exists.
// The input is not ready during a search or its result run; results leave one per cycle
// unless m_tready is low. Reset is synchronous; the match table must be loaded first.
`default_nettype none

module tournament_hamiltonian_cycle_search_core #(
  parameter int MAX_NODES = thcs_pkg::MAX_NODES_DEFAULT
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [15:0] s_tdata,   // [3:0] row_node, [7:4] col_node, [9:8] outcome, rest zero
  input  wire        s_tuser,   // [0] mode
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // [3:0] node_index, [4] found, rest zero
  output logic       m_tlast,
  input  wire        cfg_wen,
  input  wire [4:0]  cfg_wdata
);
  import thcs_pkg::*;

  localparam int LIM = (MAX_NODES < NODE_CAP) ? MAX_NODES : NODE_CAP;
  localparam int IW  = $clog2(LIM);
  localparam int DW  = $clog2(LIM + 1);

  search_state_t state, state_next;

  logic [COUNT_W-1:0] node_count;
  logic [DW-1:0]      n_eff;

  logic [IW-1:0] path_stack [LIM];
  logic [LIM-1:0] visited, visited_next;
  logic [DW-1:0]  depth, depth_next;
  logic [IW-1:0]  prev, prev_next;
  logic [IW-1:0]  start, start_next;
  logic [DW-1:0]  s_cnt, s_cnt_next;
  logic [DW-1:0]  i_cnt, i_cnt_next;
  logic [DW-1:0]  j_cnt, j_cnt_next;
  logic [DW-1:0]  k_cnt, k_cnt_next;

  logic          stack_we;
  logic [IW-1:0] stack_wa;
  logic [IW-1:0] stack_wd;
  logic [DW-1:0] depth_m2;
  logic [IW-1:0] stack_ra;
  logic [IW-1:0] stack_rd;

  logic [IW-1:0] qa, qb;
  logic          follow;
  table_write_t  tw;

  logic          out_load;
  logic [IW-1:0] out_node_d;
  logic          out_found_d;
  logic          out_last_d;
  logic [IW-1:0] out_node;
  logic          out_found;

  assign n_eff = (node_count > COUNT_W'(LIM)) ? DW'(LIM) : node_count[DW-1:0];

  assign s_tready = (state == S_IDLE);

  assign tw.en      = s_tvalid && s_tready && (s_tuser == MODE_LOAD);
  assign tw.row     = s_tdata[3:0];
  assign tw.col     = s_tdata[7:4];
  assign tw.outcome = s_tdata[9:8];

  thcs_follow_unit #(
    .MAX_NODES(MAX_NODES),
    .IW       (IW)
  ) u_follow (
    .clk   (clk),
    .wr    (tw),
    .qa    (qa),
    .qb    (qb),
    .follow(follow)
  );

  assign depth_m2 = depth - DW'(2);
  assign stack_ra = (state == S_EMIT) ? k_cnt[IW-1:0] : depth_m2[IW-1:0];
  assign stack_rd = path_stack[stack_ra];

  always_ff @(posedge clk) begin
    if (stack_we) begin
      path_stack[stack_wa] <= stack_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_wen) begin
      node_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      visited  <= '0;
      depth    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      visited <= visited_next;
      depth   <= depth_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prev  <= prev_next;
    start <= start_next;
    s_cnt <= s_cnt_next;
    i_cnt <= i_cnt_next;
    j_cnt <= j_cnt_next;
    k_cnt <= k_cnt_next;
    if (out_load) begin
      out_node  <= out_node_d;
      out_found <= out_found_d;
      m_tlast   <= out_last_d;
    end
  end

  assign m_tdata = {3'b000, out_found, NODE_W'(out_node)};

  always_comb begin
    state_next   = state;
    visited_next = visited;
    depth_next   = depth;
    prev_next    = prev;
    start_next   = start;
    s_cnt_next   = s_cnt;
    i_cnt_next   = i_cnt;
    j_cnt_next   = j_cnt;
    k_cnt_next   = k_cnt;
    stack_we     = 1'b0;
    stack_wa     = depth[IW-1:0];
    stack_wd     = i_cnt[IW-1:0];
    qa           = prev;
    qb           = i_cnt[IW-1:0];
    out_load     = 1'b0;
    out_node_d   = stack_rd;
    out_found_d  = 1'b1;
    out_last_d   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid && (s_tuser == MODE_SEARCH)) begin
          visited_next = '0;
          depth_next   = '0;
          s_cnt_next   = '0;
          state_next   = S_START;
        end
      end
      S_START: begin
        if (s_cnt == n_eff) begin
          state_next = S_EMIT_NF;
        end else begin
          stack_we     = 1'b1;
          stack_wa     = '0;
          stack_wd     = s_cnt[IW-1:0];
          visited_next = LIM'(1) << s_cnt[IW-1:0];
          depth_next   = DW'(1);
          prev_next    = s_cnt[IW-1:0];
          start_next   = s_cnt[IW-1:0];
          i_cnt_next   = '0;
          state_next   = S_TRY;
        end
      end
      S_TRY: begin
        if (i_cnt == n_eff) begin
          state_next = S_RET;
        end else if (visited[i_cnt[IW-1:0]]) begin
          state_next = S_CLOSE;
        end else begin
          state_next = S_TRY_EV;
        end
      end
      S_TRY_EV: begin
        if (follow) begin
          stack_we     = 1'b1;
          visited_next = visited | (LIM'(1) << i_cnt[IW-1:0]);
          depth_next   = depth + DW'(1);
          prev_next    = i_cnt[IW-1:0];
          i_cnt_next   = '0;
          state_next   = S_TRY;
        end else begin
          state_next = S_CLOSE;
        end
      end
      S_CLOSE: begin
        qb         = start;
        state_next = S_CLOSE_EV;
      end
      S_CLOSE_EV: begin
        if ((depth == n_eff) && follow) begin
          k_cnt_next = '0;
          state_next = S_EMIT;
        end else begin
          j_cnt_next = '0;
          state_next = S_REACH;
        end
      end
      S_REACH: begin
        qa = j_cnt[IW-1:0];
        qb = start;
        if (j_cnt == n_eff) begin
          state_next = S_RET;
        end else if (visited[j_cnt[IW-1:0]]) begin
          j_cnt_next = j_cnt + DW'(1);
        end else begin
          state_next = S_REACH_EV;
        end
      end
      S_REACH_EV: begin
        if (follow) begin
          i_cnt_next = i_cnt + DW'(1);
          state_next = S_TRY;
        end else begin
          j_cnt_next = j_cnt + DW'(1);
          state_next = S_REACH;
        end
      end
      S_RET: begin
        visited_next = visited & ~(LIM'(1) << prev);
        depth_next   = depth - DW'(1);
        if (depth == DW'(1)) begin
          s_cnt_next = s_cnt + DW'(1);
          state_next = S_START;
        end else begin
          i_cnt_next = DW'(prev);
          prev_next  = stack_rd;
          state_next = S_CLOSE;
        end
      end
      S_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load    = 1'b1;
          out_last_d  = (k_cnt == n_eff - DW'(1));
          k_cnt_next  = k_cnt + DW'(1);
          if (k_cnt == n_eff - DW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT_NF: begin
        if (!m_tvalid || m_tready) begin
          out_load    = 1'b1;
          out_node_d  = '0;
          out_found_d = 1'b0;
          out_last_d  = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_depth_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (depth <= n_eff))
    else $error("path depth exceeds the node count");

  a_visited_matches_depth: assert property (@(posedge clk) disable iff (rst)
    $countones(visited) == 32'(depth))
    else $error("visited set does not match the path depth");

  a_output_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_EMIT || $past(state) == S_EMIT_NF))
    else $error("result issued outside an emit state");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRY || state == S_REACH || state == S_RET) |-> !s_tready)
    else $error("input ready during a search");

endmodule

`default_nettype wire

### bench/tb_tournament_hamiltonian_cycle_search_core.sv
// Testbench for tournament_hamiltonian_cycle_search_core: streams match table loads and search
// requests, predicts each cycle with its own depth-first search and checks every result.
// Depends on thcs_pkg and the core RTL; needs no files or arguments.
module tb_tournament_hamiltonian_cycle_search_core;
  import thcs_pkg::*;

  localparam logic [OUTCOME_W-1:0] OUT_DRAW  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_OTHER = 2'd3;
  localparam int MAX_NODES      = MAX_NODES_DEFAULT;
  localparam int RANDOM_ITEMS   = 40;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 300000;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              found;
    logic              last;
  } cycle_entry_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [15:0] s_tdata = '0;  // [3:0] row_node, [7:4] col_node, [9:8] outcome, rest zero
  logic       s_tuser = 1'b0; // [0] mode
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;        // [3:0] node_index, [4] found, rest zero
  logic       m_tlast;
  logic       cfg_wen = 1'b0;
  logic [4:0] cfg_wdata = '0;

  tournament_hamiltonian_cycle_search_core u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  logic [OUTCOME_W-1:0] match_tbl [16][16];
  bit                   tbl_written [16][16];
  int                   path_nodes [16];
  int                   path_len = 0;
  logic [15:0]          visited_set = '0;
  logic [COUNT_W-1:0]   node_count_q = NODE_COUNT_RESET;

  cycle_entry_t expected_cycle_q[$];
  int  mismatches = 0;
  int  results_checked = 0;
  int  items_sent = 0;
  int  searches_run = 0;
  int  cycles_found = 0;
  int  burst_left = 0;
  int  quiet_cycles = 0;
  bit  steady_send = 0;
  bit  hold_results = 0;

  function automatic bit may_follow(int a, int b);
    return match_tbl[a][b] == OUT_WIN || match_tbl[b][a] == OUT_LOSS;
  endfunction

  function automatic bit back_to_start_open(int n);
    for (int i = 0; i < n; i++)
      if (!visited_set[i] && may_follow(i, path_nodes[0])) return 1;
    return 0;
  endfunction

  function automatic bit cycle_done(int n);
    return path_len == n && path_len > 0 && may_follow(path_nodes[path_len-1], path_nodes[0]);
  endfunction

  // Depth-first extension of the path, with an explicit stack of scan positions per level.
  function automatic bit grow_path(int n);
    int scan_at[18];
    int lvl;
    int base;
    int cand;
    bit child_failed;
    base = path_len;
    lvl = base;
    scan_at[lvl] = 0;
    child_failed = 0;
    forever begin
      if (child_failed) begin
        child_failed = 0;
        cand = scan_at[lvl];
        path_len--;
        visited_set[cand] = 1'b0;
      end else if (scan_at[lvl] >= n) begin
        if (lvl == base) return 0;
        lvl--;
        child_failed = 1;
        continue;
      end else begin
        cand = scan_at[lvl];
        if (!visited_set[cand] && may_follow(path_nodes[lvl-1], cand)) begin
          path_nodes[path_len] = cand;
          path_len++;
          visited_set[cand] = 1'b1;
          lvl++;
          scan_at[lvl] = 0;
          continue;
        end
      end
      if (cycle_done(n)) return 1;
      if (!back_to_start_open(n)) begin
        if (lvl == base) return 0;
        lvl--;
        child_failed = 1;
        continue;
      end
      scan_at[lvl]++;
    end
  endfunction

  task automatic predict_search();
    int n;
    bit hit;
    cycle_entry_t entry;
    n = (node_count_q > MAX_NODES) ? MAX_NODES : node_count_q;
    path_nodes = '{default: 0};
    visited_set = '0;
    path_len = 0;
    hit = 0;
    for (int s = 0; s < n && !hit; s++) begin
      path_nodes[path_len] = s;
      path_len++;
      visited_set[s] = 1'b1;
      if (grow_path(n)) begin
        hit = 1;
      end else begin
        path_len--;
        visited_set[s] = 1'b0;
      end
    end
    searches_run++;
    if (hit) begin
      cycles_found++;
      for (int k = 0; k < n; k++) begin
        entry = '{node: 4'(path_nodes[k]), found: 1'b1, last: (k == n - 1)};
        expected_cycle_q = {expected_cycle_q, entry};
      end
    end else begin
      entry = '{node: 4'd0, found: 1'b0, last: 1'b1};
      expected_cycle_q = {expected_cycle_q, entry};
    end
  endtask

  task automatic send_request(logic mode, logic [3:0] row, logic [3:0] col, logic [1:0] oc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, oc, col, row};
    s_tuser <= mode;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (mode == MODE_SEARCH) begin
      predict_search();
    end else begin
      match_tbl[row][col] = oc;
      tbl_written[row][col] = 1;
    end
  endtask

  task automatic send_search();
    send_request(MODE_SEARCH, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 2'($urandom_range(0, 3)));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_cycle_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(logic [4:0] value);
    wait_results_drained();
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    node_count_q = value;
  endtask

  // Builds a table whose follow relation is a transitive order along a node sequence, except
  // that its first node follows its last, so that the search finds a cycle without much
  // backtracking. Each direction is encoded at random through win, loss, draw and code three.
  task automatic load_chain(int n, bit scramble);
    int order[16];
    logic [1:0] plan[16][16];
    int j;
    int t;
    int u;
    int v;
    for (int i = 0; i < 16; i++) order[i] = i;
    if (scramble) begin
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
    end
    for (int x = 0; x < n; x++) begin
      plan[order[x]][order[x]] = 2'($urandom_range(0, 3));
      for (int y = x + 1; y < n; y++) begin
        u = order[x];
        v = order[y];
        if (x == 0 && y == n - 1) begin
          t = u;
          u = v;
          v = t;
        end
        case ($urandom_range(0, 4))
          0: begin plan[u][v] = OUT_WIN;   plan[v][u] = OUT_DRAW;  end
          1: begin plan[u][v] = OUT_WIN;   plan[v][u] = OUT_LOSS;  end
          2: begin plan[u][v] = OUT_WIN;   plan[v][u] = OUT_OTHER; end
          3: begin plan[u][v] = OUT_DRAW;  plan[v][u] = OUT_LOSS;  end
          default: begin plan[u][v] = OUT_OTHER; plan[v][u] = OUT_LOSS; end
        endcase
      end
    end
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        send_request(MODE_LOAD, 4'(r), 4'(c), plan[r][c]);
  endtask

  // Fills every unwritten entry of the active block, rewrites a few others and adds some stray
  // writes anywhere in the table, all in random order with random outcomes.
  task automatic load_random_block(int n);
    logic [7:0] cells[$];
    logic [7:0] swap;
    int j;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (!tbl_written[r][c]) cells = {cells, 8'(r * 16 + c)};
    repeat ($urandom_range(1, n + 2))
      cells = {cells, 8'($urandom_range(0, n - 1) * 16 + $urandom_range(0, n - 1))};
    repeat ($urandom_range(0, 2)) cells = {cells, 8'($urandom_range(0, 255))};
    for (int i = cells.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = cells[i];
      cells[i] = cells[j];
      cells[j] = swap;
    end
    foreach (cells[i])
      send_request(MODE_LOAD, cells[i][7:4], cells[i][3:0], 2'($urandom_range(0, 3)));
  endtask

  task automatic test_empty_count();
    write_node_count(5'd0);
    send_search();
  endtask

  task automatic test_single_node();
    write_node_count(5'd1);
    send_request(MODE_LOAD, 4'd0, 4'd0, OUT_DRAW);
    send_search();
    send_request(MODE_LOAD, 4'd0, 4'd0, OUT_OTHER);
    send_search();
    send_request(MODE_LOAD, 4'd0, 4'd0, OUT_WIN);
    send_search();
    send_request(MODE_LOAD, 4'd0, 4'd0, OUT_LOSS);
    send_search();
  endtask

  task automatic test_two_nodes();
    write_node_count(5'd2);
    send_request(MODE_LOAD, 4'd0, 4'd0, OUT_OTHER);
    send_request(MODE_LOAD, 4'd1, 4'd1, OUT_DRAW);
    send_request(MODE_LOAD, 4'd0, 4'd1, OUT_WIN);
    send_request(MODE_LOAD, 4'd1, 4'd0, OUT_WIN);
    send_search();
    send_request(MODE_LOAD, 4'd1, 4'd0, OUT_LOSS);
    send_search();
    send_request(MODE_LOAD, 4'd0, 4'd1, OUT_LOSS);
    send_search();
  endtask

  // Code three in the table must act as a draw; writes at the far corners must not disturb it.
  task automatic test_three_nodes();
    write_node_count(5'd3);
    send_request(MODE_LOAD, 4'd0, 4'd0, OUT_DRAW);
    send_request(MODE_LOAD, 4'd0, 4'd1, OUT_WIN);
    send_request(MODE_LOAD, 4'd0, 4'd2, OUT_OTHER);
    send_request(MODE_LOAD, 4'd1, 4'd0, OUT_OTHER);
    send_request(MODE_LOAD, 4'd1, 4'd1, OUT_WIN);
    send_request(MODE_LOAD, 4'd1, 4'd2, OUT_DRAW);
    send_request(MODE_LOAD, 4'd2, 4'd0, OUT_WIN);
    send_request(MODE_LOAD, 4'd2, 4'd1, OUT_LOSS);
    send_request(MODE_LOAD, 4'd2, 4'd2, OUT_LOSS);
    send_search();
    send_request(MODE_LOAD, 4'd15, 4'd15, OUT_OTHER);
    send_request(MODE_LOAD, 4'd0, 4'd15, OUT_WIN);
    send_request(MODE_LOAD, 4'd15, 4'd0, OUT_LOSS);
    send_search();
    send_request(MODE_LOAD, 4'd2, 4'd0, OUT_OTHER);
    send_search();
  endtask

  task automatic test_full_size_and_backpressure();
    logic [3:0] r;
    logic [3:0] c;
    load_chain(16, 0);
    write_node_count(5'd31);
    send_search();
    write_node_count(5'd17);
    send_search();
    write_node_count(5'd16);
    steady_send = 1;
    hold_results = 1;
    send_search();
    repeat (6) begin
      r = 4'($urandom_range(0, 15));
      c = 4'($urandom_range(0, 15));
      send_request(MODE_LOAD, r, c, match_tbl[r][c]);
    end
    send_search();
    steady_send = 0;
  endtask

  task automatic test_random_sets();
    int n;
    int first_item;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(6, 8);
        write_node_count(5'(n));
        load_chain(n, 1);
      end else begin
        n = $urandom_range(1, 5);
        write_node_count(5'(n));
        load_random_block(n);
      end
      send_search();
      if ($urandom_range(0, 2) == 0 && n <= 5) begin
        load_random_block(n);
        send_search();
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    cycle_entry_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (expected_cycle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result with nothing pending: tdata=%h tlast=%b", m_tdata, m_tlast);
      end else begin
        want = expected_cycle_q.pop_front();
        if (m_tdata !== {3'b000, want.found, want.node} || m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d wrong: expected node=%0d found=%b last=%b, got tdata=%h tlast=%b",
                     results_checked, want.node, want.found, want.last, m_tdata, m_tlast);
        end
      end
    end
  end

  initial begin : result_sink
    int phase_left;
    int ready_pct;
    int hold_left;
    phase_left = 0;
    ready_pct = 100;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0: ready_pct = 100;
          1: ready_pct = 60;
          default: ready_pct = 25;
        endcase
      end
      phase_left--;
      if (hold_results && m_tvalid && hold_left == 0) begin
        hold_results = 0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results still pending.", expected_cycle_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_count();
    test_single_node();
    test_two_nodes();
    test_three_nodes();
    test_full_size_and_backpressure();
    test_random_sets();
    wait_results_drained();
    repeat (40) @(posedge clk);
    $display("Checked %0d results from %0d searches (%0d cycles, %0d without) over %0d requests.",
             results_checked, searches_run, cycles_found, searches_run - cycles_found, items_sent);
    $display("Node counts 0, 1, 2, 3, 16, 17, 31 and random sizes ran under input gaps and stalls.");
    if (mismatches == 0 && expected_cycle_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
